### rtl/psm_pkg.sv
`timescale 1ns / 1ps
package psm_pkg;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 12;
    localparam int ROW_BITS       = 12;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRAY_MODE  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        GRAY_LUMA = 2'd0,
        GRAY_AVG  = 2'd1,
        GRAY_MID  = 2'd2
    } gray_mode_t;

    localparam logic [ROW_BITS-1:0] ROW_LENGTH_RESET = 12'd900;
    localparam logic [6:0]          NEWLINE_CODE     = 7'd10;

    // Q16 luminosity weights, 0.21 / 0.72 / 0.07; they sum to 65536
    localparam logic [15:0] LUMA_W_RED   = 16'd13763;
    localparam logic [15:0] LUMA_W_GREEN = 16'd47186;
    localparam logic [15:0] LUMA_W_BLUE  = 16'd4587;

    // floor(s / 3) == (s * 683) >> 11 for every s below 2048
    localparam logic [10:0] AVG_RECIP = 11'd683;
    localparam int          AVG_SHIFT = 11;

    localparam int SHADE_LEVELS = 13;

    localparam logic [7:0] SHADE_LIMITS [SHADE_LEVELS-1] = '{
        8'd240, 8'd220, 8'd200, 8'd175, 8'd150, 8'd125,
        8'd100, 8'd80,  8'd55,  8'd40,  8'd25,  8'd10
    };

    // ' ' '.' '^' '!' '{' 'L' 'p' 'o' '8' '%' 'B' '@' '$'
    localparam logic [6:0] SHADE_CODES [SHADE_LEVELS] = '{
        7'h20, 7'h2E, 7'h5E, 7'h21, 7'h7B, 7'h4C, 7'h70,
        7'h6F, 7'h38, 7'h25, 7'h42, 7'h40, 7'h24
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [6:0] shade;
        logic [7:0] gray;
        logic       row_end;
    } pixel_result_t;

    // First threshold the gray level reaches picks the character
    function automatic logic [6:0] shade_of(input logic [7:0] gray);
        logic [6:0] code;
        code = SHADE_CODES[SHADE_LEVELS-1];
        for (int i = SHADE_LEVELS - 2; i >= 0; i--)
        begin
            if (gray >= SHADE_LIMITS[i])
            begin
                code = SHADE_CODES[i];
            end
        end
        return code;
    endfunction

endpackage

### rtl/psm_pixel_if.sv
`timescale 1ns / 1ps
interface psm_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;

    modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                    input ready);
    modport sink   (input valid, input pixel_red, input pixel_green, input pixel_blue,
                    output ready);
endinterface

### rtl/psm_shade_if.sv
`timescale 1ns / 1ps
interface psm_shade_if;
    logic       valid;
    logic       ready;
    logic [6:0] shade_char;
    logic [7:0] gray_value;
    logic       last_result;

    modport source (output valid, output shade_char, output gray_value, output last_result,
                    input ready);
    modport sink   (input valid, input shade_char, input gray_value, input last_result,
                    output ready);
endinterface

### rtl/psm_gray_unit.sv
`timescale 1ns / 1ps
module psm_gray_unit
    import psm_pkg::*;
(
    input  pixel_t     pix,
    input  logic [1:0] mode,
    output logic [7:0] gray,
    output logic [6:0] shade
);

    logic [23:0] luma_sum;
    logic [9:0]  chan_sum;
    logic [20:0] avg_prod;
    logic [7:0]  chan_max;
    logic [7:0]  chan_min;
    logic [8:0]  mid_sum;

    always_comb
    begin
        luma_sum = 24'(LUMA_W_RED) * 24'(pix.red)
                 + 24'(LUMA_W_GREEN) * 24'(pix.green)
                 + 24'(LUMA_W_BLUE) * 24'(pix.blue);

        chan_sum = 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
        avg_prod = 21'(chan_sum) * 21'(AVG_RECIP);

        chan_max = pix.red;
        if (pix.green > chan_max)
        begin
            chan_max = pix.green;
        end
        if (pix.blue > chan_max)
        begin
            chan_max = pix.blue;
        end
        chan_min = pix.red;
        if (pix.green < chan_min)
        begin
            chan_min = pix.green;
        end
        if (pix.blue < chan_min)
        begin
            chan_min = pix.blue;
        end
        mid_sum = 9'(chan_max) + 9'(chan_min);

        // the unused mode code falls back to the midpoint
        case (mode)
            GRAY_LUMA: gray = luma_sum[23:16];
            GRAY_AVG:  gray = avg_prod[AVG_SHIFT+7:AVG_SHIFT];
            default:   gray = mid_sum[8:1];
        endcase

        shade = shade_of(gray);
    end

endmodule

### rtl/psm_row_counter.sv
`timescale 1ns / 1ps
module psm_row_counter
    import psm_pkg::*;
#(
    parameter int COLUMN_BITS = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [ROW_BITS-1:0] row_length,
    output logic                row_end
);

    localparam int CMP_BITS = (COLUMN_BITS + 1 > ROW_BITS) ? COLUMN_BITS + 1 : ROW_BITS;

    logic [COLUMN_BITS-1:0] count_reg;
    logic [COLUMN_BITS-1:0] count_next;
    logic [COLUMN_BITS:0]   bumped;

    always_comb
    begin
        bumped = {1'b0, count_reg} + (COLUMN_BITS + 1)'(1);
        // a zero row length ends every row; a wrapped counter ends it too
        row_end = (CMP_BITS'(bumped) >= CMP_BITS'(row_length)) || bumped[COLUMN_BITS];
        count_next = count_reg;
        if (advance)
        begin
            count_next = row_end ? '0 : bumped[COLUMN_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

### rtl/psm_result_stage.sv
`timescale 1ns / 1ps
module psm_result_stage
    import psm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  pixel_result_t load_data,
    output logic          free,
    psm_shade_if.source   result
);

    logic       valid_reg;
    logic       valid_next;
    logic       nl_pend_reg;
    logic       nl_pend_next;
    logic [6:0] shade_reg;
    logic [6:0] shade_next;
    logic [7:0] gray_reg;
    logic [7:0] gray_next;
    logic       last_reg;
    logic       last_next;
    logic       take;

    always_comb
    begin
        take = valid_reg && result.ready;
        // the slot frees only once no newline is left behind the shown item
        free = !valid_reg || (result.ready && !nl_pend_reg);

        valid_next   = valid_reg;
        nl_pend_next = nl_pend_reg;
        shade_next   = shade_reg;
        gray_next    = gray_reg;
        last_next    = last_reg;

        if (take && nl_pend_reg)
        begin
            nl_pend_next = 1'b0;
            shade_next   = NEWLINE_CODE;
            gray_next    = 8'd0;
            last_next    = 1'b1;
        end
        else if (load)
        begin
            valid_next   = 1'b1;
            nl_pend_next = load_data.row_end;
            shade_next   = load_data.shade;
            gray_next    = load_data.gray;
            last_next    = !load_data.row_end;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            nl_pend_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            nl_pend_reg <= nl_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shade_reg <= shade_next;
        gray_reg  <= gray_next;
        last_reg  <= last_next;
    end

    assign result.valid       = valid_reg;
    assign result.shade_char  = shade_reg;
    assign result.gray_value  = gray_reg;
    assign result.last_result = last_reg;

endmodule

### rtl/pixel_to_ascii_shade_mapper.sv
`timescale 1ns / 1ps
// Pixel to ASCII shade mapper.
// pixel: one RGB pixel per item (valid/ready). result: one shade character
// per pixel, plus a newline item (code 10, gray 0) after the last pixel of
// each row; last_result marks the final item a pixel causes.
// Configuration: wr_en/wr_index/wr_data; index 0 is gray_mode (0 luminosity,
// 1 average, 2 or 3 midpoint of max and min), index 1 is row_length.
// Write registers only while no pixel is in flight.
// A pixel accepted into the input register has its result worked out
// combinationally and loaded into the result register once that is free;
// the result is valid from then on.
// Throughput: one pixel per cycle while the receiver takes results; after a
// row end the single result register holds the pixel and then the newline
// and takes no new pixel until the newline is taken.
// Reset: gray_mode 2, row_length 900, column count 0, both stages empty.
// When the receiver stalls, the result register holds its item; the input
// register takes a pixel only while it is empty, and pixel.ready then drops.
module pixel_to_ascii_shade_mapper
    import psm_pkg::*;
#(
    parameter int COLUMN_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [CFG_INDEX_BITS-1:0] wr_index,
    input  logic [CFG_DATA_BITS-1:0]  wr_data,
    psm_pixel_if.sink                 pixel,
    psm_shade_if.source               result
);

    logic [1:0]          gray_mode_reg;
    logic [ROW_BITS-1:0] row_length_reg;
    logic                in_valid_reg;
    pixel_t              in_pix_reg;
    logic                out_free;
    logic                advance;
    logic                row_end;
    logic [7:0]          gray;
    logic [6:0]          shade;
    pixel_result_t       stage_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_mode_reg  <= GRAY_MID;
            row_length_reg <= ROW_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_GRAY_MODE:  gray_mode_reg  <= wr_data[1:0];
                REG_ROW_LENGTH: row_length_reg <= wr_data[ROW_BITS-1:0];
                default:        ;
            endcase
        end
    end

    assign pixel.ready = !in_valid_reg || out_free;
    assign advance     = in_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pixel.ready)
        begin
            in_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel.valid && pixel.ready)
        begin
            in_pix_reg <= '{red: pixel.pixel_red, green: pixel.pixel_green,
                            blue: pixel.pixel_blue};
        end
    end

    psm_gray_unit u_gray
    (
        .pix   (in_pix_reg),
        .mode  (gray_mode_reg),
        .gray  (gray),
        .shade (shade)
    );

    psm_row_counter #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_row
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .row_length (row_length_reg),
        .row_end    (row_end)
    );

    assign stage_data = '{shade: shade, gray: gray, row_end: row_end};

    psm_result_stage u_result
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .load_data (stage_data),
        .free      (out_free),
        .result    (result)
    );

    // a pixel that ends a row is always followed by its newline
    a_newline_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && !result.last_result
        |=> result.valid && result.shade_char == NEWLINE_CODE)
        else $error("row end pixel not followed by newline");

    a_newline_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.shade_char == NEWLINE_CODE
        |-> result.gray_value == 8'd0 && result.last_result)
        else $error("newline item carries a bad payload");

    // the input side stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> result.valid)
        else $error("pixel stalled with no result pending");

endmodule
